FILE: hw/rtl/ndts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ndts_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OFFSET_EXT_BITS = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

    localparam logic [7:0] TAG_NULL = 8'h00;
    localparam logic [7:0] TAG_NDEF = 8'h03;
    localparam logic [7:0] TAG_TERMINATOR = 8'hFE;
    localparam logic [7:0] LEN_ESCAPE = 8'hFF;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_TERM  = 2'd1,
        ST_TRUNC = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_LEN    = 5'b00010,
        PH_LEN_HI = 5'b00100,
        PH_LEN_LO = 5'b01000,
        PH_VALUE  = 5'b10000
    } phase_t;

    typedef struct packed {
        status_t     scan_status;
        logic [15:0] value_offset;
        logic [15:0] value_length;
    } result_t;

    function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] pos);
        logic [OFFSET_BITS-1:0] r;
        if (pos == POS_MAX)
        begin
            r = pos;
        end
        else
        begin
            r = pos + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_offset(input logic [OFFSET_BITS-1:0] pos);
        logic [OFFSET_EXT_BITS-1:0] w;
        logic [15:0] r;
        w = OFFSET_EXT_BITS'(pos);
        if (w > OFFSET_EXT_BITS'(16'hFFFF))
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = w[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ndts_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ndts_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       advance,
    output logic            item_full,
    output logic [7:0]      item_byte,
    output logic            item_last
);
    import ndts_pkg::*;

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       take;

    assign in_stall = full_reg && !advance;
    assign take = in_valid && !in_stall;

    always_comb
    begin
        full_next = take || (full_reg && !advance);
        byte_next = take ? data_byte : byte_reg;
        last_next = take ? last_byte : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign item_full = full_reg;
    assign item_byte = byte_reg;
    assign item_last = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ndts_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ndts_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic [7:0]       item_byte,
    input  wire logic             item_last,
    output logic                  res_valid,
    output ndts_pkg::result_t     res
);
    import ndts_pkg::*;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic                   ndef_reg;
    logic                   ndef_next;
    logic [15:0]            acc_reg;
    logic [15:0]            acc_next;
    logic [15:0]            rem_reg;
    logic [15:0]            rem_next;
    logic [OFFSET_BITS-1:0] vstart_reg;
    logic [OFFSET_BITS-1:0] vstart_next;
    logic                   given_reg;
    logic                   given_next;

    logic                   emit;
    result_t                res_c;
    logic                   len_done;
    logic [15:0]            len_val;
    logic [15:0]            rem_dec;
    logic [OFFSET_BITS-1:0] pos_inc_c;

    assign pos_inc_c = pos_inc(pos_reg);
    assign rem_dec = rem_reg - 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        ndef_next = ndef_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        vstart_next = vstart_reg;
        given_next = given_reg;
        emit = 1'b0;
        res_c.scan_status = ST_NONE;
        res_c.value_offset = 16'd0;
        res_c.value_length = 16'd0;
        len_done = 1'b0;
        len_val = 16'd0;

        if (item_valid && !given_reg)
        begin
            pos_next = pos_inc_c;
            unique case (phase_reg)
                PH_TAG:
                begin
                    if (item_byte == TAG_NULL)
                    begin
                        if (item_last)
                        begin
                            emit = 1'b1;
                            res_c.scan_status = ST_NONE;
                        end
                    end
                    else if (item_byte == TAG_TERMINATOR)
                    begin
                        emit = 1'b1;
                        res_c.scan_status = ST_TERM;
                    end
                    else
                    begin
                        ndef_next = (item_byte == TAG_NDEF);
                        if (item_last)
                        begin
                            emit = 1'b1;
                            res_c.scan_status = ST_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (item_byte == LEN_ESCAPE)
                    begin
                        if (item_last)
                        begin
                            emit = 1'b1;
                            res_c.scan_status = ST_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                    else
                    begin
                        len_done = 1'b1;
                        len_val = {8'd0, item_byte};
                    end
                end
                PH_LEN_HI:
                begin
                    acc_next = {item_byte, 8'd0};
                    if (item_last)
                    begin
                        emit = 1'b1;
                        res_c.scan_status = ST_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    len_done = 1'b1;
                    len_val = {acc_reg[15:8], item_byte};
                end
                PH_VALUE:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        if (ndef_reg)
                        begin
                            emit = 1'b1;
                            res_c.scan_status = ST_FOUND;
                            res_c.value_offset = clamp_offset(vstart_reg);
                            res_c.value_length = acc_reg;
                        end
                        else if (item_last)
                        begin
                            emit = 1'b1;
                            res_c.scan_status = ST_NONE;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    else if (item_last)
                    begin
                        emit = 1'b1;
                        res_c.scan_status = ST_TRUNC;
                    end
                end
                default:
                begin
                    phase_next = PH_TAG;
                    if (item_last)
                    begin
                        emit = 1'b1;
                        res_c.scan_status = ST_NONE;
                    end
                end
            endcase

            if (len_done)
            begin
                acc_next = len_val;
                vstart_next = pos_inc_c;
                if (len_val == 16'd0)
                begin
                    if (ndef_reg)
                    begin
                        emit = 1'b1;
                        res_c.scan_status = ST_FOUND;
                        res_c.value_offset = clamp_offset(pos_inc_c);
                        res_c.value_length = 16'd0;
                    end
                    else if (item_last)
                    begin
                        emit = 1'b1;
                        res_c.scan_status = ST_NONE;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                else if (item_last)
                begin
                    emit = 1'b1;
                    res_c.scan_status = ST_TRUNC;
                end
                else
                begin
                    rem_next = len_val;
                    phase_next = PH_VALUE;
                end
            end

            if (emit)
            begin
                given_next = 1'b1;
            end
        end

        // The last byte of a buffer always rearms the scanner for the next one.
        if (item_valid && item_last)
        begin
            phase_next = PH_TAG;
            pos_next = '0;
            ndef_next = 1'b0;
            acc_next = 16'd0;
            rem_next = 16'd0;
            vstart_next = '0;
            given_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            pos_reg <= '0;
            ndef_reg <= 1'b0;
            acc_reg <= 16'd0;
            rem_reg <= 16'd0;
            vstart_reg <= '0;
            given_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            ndef_reg <= ndef_next;
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            vstart_reg <= vstart_next;
            given_reg <= given_next;
        end
    end

    assign res_valid = emit;
    assign res = res_c;

`ifndef ASSERT_OFF
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (item_valid && !given_reg))
        else $error("Second result produced for one buffer.");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_last) |=> (!given_reg && pos_reg == '0 && phase_reg == PH_TAG))
        else $error("Scanner not rearmed after the last byte.");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_c.scan_status != ST_FOUND) |->
            (res_c.value_offset == 16'd0 && res_c.value_length == 16'd0))
        else $error("Non-NDEF result carries offset or length.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ndts_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module ndts_out_buf
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ndts_pkg::result_t  push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              scan_status,
    output logic [15:0]             value_offset,
    output logic [15:0]             value_length
);
    import ndts_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    spare_reg;
    result_t    spare_next;
    logic       pop;

    assign pop = (count_reg != 2'd0) && !out_stall;

    always_comb
    begin
        head_next = head_reg;
        spare_next = spare_reg;
        count_next = count_reg;
        if (pop && count_reg == 2'd2)
        begin
            head_next = spare_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                head_next = push_data;
            end
            else
            begin
                spare_next = push_data;
            end
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        spare_reg <= spare_next;
    end

    assign full = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign scan_status = head_reg.scan_status;
    assign value_offset = head_reg.value_offset;
    assign value_length = head_reg.value_length;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("Output buffer count out of range.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("Push into a full output buffer.");

    a_stalled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(head_reg)))
        else $error("Stalled output transaction changed.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ndef_tlv_scanner_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// input     in_valid / in_stall       data_byte, last_byte
// output    out_valid / out_stall     scan_status, value_offset, value_length
//
// One byte is taken every cycle while in_stall is low.
// The input register feeds the scan logic, which writes a two-entry output buffer.
// Input stalls only when that output buffer is full and the input register holds a byte.
// Reset clears the scan state, so the first byte after reset starts a new buffer.
// Each buffer produces exactly one transaction on the output.

module ndef_tlv_scanner_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       scan_status,
    output logic [15:0]      value_offset,
    output logic [15:0]      value_length
);
    import ndts_pkg::*;

    logic        item_full;
    logic [7:0]  item_byte;
    logic        item_last;
    logic        advance;
    logic        res_valid;
    result_t     res;
    logic        buf_full;

    assign advance = item_full && !buf_full;

    ndts_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .advance   (advance),
        .item_full (item_full),
        .item_byte (item_byte),
        .item_last (item_last)
    );

    ndts_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item_byte  (item_byte),
        .item_last  (item_last),
        .res_valid  (res_valid),
        .res        (res)
    );

    ndts_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_valid),
        .push_data    (res),
        .full         (buf_full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scan_status  (scan_status),
        .value_offset (value_offset),
        .value_length (value_length)
    );

endmodule

`default_nettype wire
